FILE: sv/assert_macros.svh
// assertion macros used by the checker file dfr_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: %m");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: %m");

`endif

FILE: sv/dfr_pkg.sv
// types and constants for the dhcp fqdn flag rewriter
// no dependencies
`default_nettype none

package dfr_pkg;

   localparam int HEADER_LENGTH_DEFAULT  = 236;
   localparam int POSITION_WIDTH_DEFAULT = 16;
   localparam int COOKIE_BYTES           = 4;

   localparam logic [31:0] MAGIC_COOKIE    = 32'h6382_5363;
   localparam logic [7:0]  OPT_PAD         = 8'd0;
   localparam logic [7:0]  OPT_FQDN        = 8'd81;
   localparam logic [7:0]  OPT_END         = 8'd255;
   localparam logic [7:0]  FLAG_TEST_MASK  = 8'h09;
   localparam logic [7:0]  FLAG_CLEAR_MASK = 8'hF7;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_COOKIE = 3'd1,
      PH_CODE   = 3'd2,
      PH_LEN    = 3'd3,
      PH_BODY   = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_SHORT_HEADER = 3'd1,
      ST_NO_OPTIONS   = 3'd2,
      ST_SHORT_COOKIE = 3'd3,
      ST_BAD_COOKIE   = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       drop;
      logic [2:0] status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/dfr_parser.sv
// option walker: parse state and per-byte rewrite and status logic
// depends on dfr_pkg
`default_nettype none

module dfr_parser #(
   parameter int HEADER_LENGTH  = dfr_pkg::HEADER_LENGTH_DEFAULT,
   parameter int POSITION_WIDTH = dfr_pkg::POSITION_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire dfr_pkg::req_type item,
   output dfr_pkg::rsp_type      result
);

   localparam logic [POSITION_WIDTH-1:0] HDR_POS = POSITION_WIDTH'(HEADER_LENGTH);
   localparam logic [POSITION_WIDTH-1:0] COOKIE_END_POS =
      POSITION_WIDTH'(HEADER_LENGTH + dfr_pkg::COOKIE_BYTES);

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   dfr_pkg::phase_type        phase_ff, phase_in;
   logic [23:0]               cookie_ff, cookie_in;
   logic [7:0]                left_ff, left_in;
   logic                      fqdn_ff, fqdn_in;
   logic                      first_ff, first_in;
   logic                      bad_cookie_ff, bad_cookie_in;

   logic [7:0] b;
   logic [7:0] left_dec;

   assign b        = item.data_byte;
   assign left_dec = left_ff - 8'd1;
   // position saturates at all ones
   assign pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      cookie_in     = cookie_ff;
      left_in       = left_ff;
      fqdn_in       = fqdn_ff;
      first_in      = first_ff;
      bad_cookie_in = bad_cookie_ff;
      case (phase_ff)
         dfr_pkg::PH_HEADER: begin
            if (pos_in >= HDR_POS) begin
               phase_in = dfr_pkg::PH_COOKIE;
            end
         end
         dfr_pkg::PH_COOKIE: begin
            cookie_in = {cookie_ff[15:0], b};
            if (pos_in >= COOKIE_END_POS) begin
               if ({cookie_ff, b} == dfr_pkg::MAGIC_COOKIE) begin
                  phase_in = dfr_pkg::PH_CODE;
               end else begin
                  bad_cookie_in = 1'b1;
                  phase_in      = dfr_pkg::PH_DONE;
               end
            end
         end
         dfr_pkg::PH_CODE: begin
            if (b == dfr_pkg::OPT_END) begin
               phase_in = dfr_pkg::PH_DONE;
            end else if (b != dfr_pkg::OPT_PAD) begin
               fqdn_in  = (b == dfr_pkg::OPT_FQDN);
               phase_in = dfr_pkg::PH_LEN;
            end
         end
         dfr_pkg::PH_LEN: begin
            left_in = b;
            if (b == 8'd0) begin
               fqdn_in  = 1'b0;
               phase_in = dfr_pkg::PH_CODE;
            end else begin
               first_in = fqdn_ff;
               phase_in = dfr_pkg::PH_BODY;
            end
         end
         dfr_pkg::PH_BODY: begin
            first_in = 1'b0;
            left_in  = left_dec;
            if (left_dec == 8'd0) begin
               fqdn_in  = 1'b0;
               phase_in = dfr_pkg::PH_CODE;
            end
         end
         default: begin
            phase_in = dfr_pkg::PH_DONE;
         end
      endcase
   end

   // outputs
   always_comb begin
      dfr_pkg::status_type st;
      st = dfr_pkg::ST_OK;
      if (item.is_last) begin
         case (phase_in)
            dfr_pkg::PH_HEADER: st = dfr_pkg::ST_SHORT_HEADER;
            dfr_pkg::PH_COOKIE: begin
               st = (pos_in == HDR_POS) ? dfr_pkg::ST_NO_OPTIONS : dfr_pkg::ST_SHORT_COOKIE;
            end
            default: st = bad_cookie_in ? dfr_pkg::ST_BAD_COOKIE : dfr_pkg::ST_OK;
         endcase
      end
      result.out_byte = b;
      if (phase_ff == dfr_pkg::PH_BODY && first_ff &&
          (b & dfr_pkg::FLAG_TEST_MASK) == dfr_pkg::FLAG_TEST_MASK) begin
         result.out_byte = b & dfr_pkg::FLAG_CLEAR_MASK;
      end
      result.out_last = item.is_last;
      result.drop     = (st != dfr_pkg::ST_OK);
      result.status   = st;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.is_last)) begin
         pos_ff        <= '0;
         phase_ff      <= dfr_pkg::PH_HEADER;
         cookie_ff     <= '0;
         left_ff       <= '0;
         fqdn_ff       <= 1'b0;
         first_ff      <= 1'b0;
         bad_cookie_ff <= 1'b0;
      end else if (step) begin
         pos_ff        <= pos_in;
         phase_ff      <= phase_in;
         cookie_ff     <= cookie_in;
         left_ff       <= left_in;
         fqdn_ff       <= fqdn_in;
         first_ff      <= first_in;
         bad_cookie_ff <= bad_cookie_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/dhcp_fqdn_flag_rewriter_unit.sv
// DHCPv4 option walker that clears the FQDN N bit when N and S are both set
// Usage:
//   req channel carries one packet byte per request with is_last on the final
//   byte; rsp channel returns one result per request in the same order, with
//   the byte passed through or the FQDN flags byte with bit 3 cleared.
//   drop and status are meaningful on the last byte only (zero elsewhere).
// A request accepted into the input register shows on rsp_valid once it moves to the result register.
// Throughput: one request per cycle while rsp_ready stays high; the parse state update is a single
//   pass of logic between the input register and the result register.
// Parser state returns to its reset values after each last byte, so
//   packets follow one another with no gap.
// Reset clears both register stages and the parse state.
// When rsp_ready is low the result holds; the input register still takes
//   one more request, then req_ready falls until the result is taken.
// Depends on dfr_pkg and dfr_parser.
`default_nettype none

module dhcp_fqdn_flag_rewriter_unit #(
   parameter int HEADER_LENGTH  = dfr_pkg::HEADER_LENGTH_DEFAULT,
   parameter int POSITION_WIDTH = dfr_pkg::POSITION_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dfr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dfr_pkg::rsp_type      rsp_data
);

   logic             in_valid_ff;
   dfr_pkg::req_type in_ff;
   logic             out_valid_ff;
   dfr_pkg::rsp_type out_ff;
   dfr_pkg::rsp_type result;
   logic             advance;

   // request moves into the result register when that is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   dfr_parser #(
      .HEADER_LENGTH (HEADER_LENGTH),
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

endmodule

`default_nettype wire

FILE: sv/dfr_checker.sv
// port-level checks for dhcp_fqdn_flag_rewriter_unit, bound to the top level
// depends on dfr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dfr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire dfr_pkg::rsp_type rsp_data
);

   `ASSERT_NOW(a_drop_matches_status, clock, reset, rsp_valid, rsp_data.drop == (rsp_data.status != dfr_pkg::ST_OK))
   `ASSERT_NOW(a_status_only_on_last, clock, reset, rsp_valid && !rsp_data.out_last, rsp_data.status == dfr_pkg::ST_OK && !rsp_data.drop)
   `ASSERT_NEXT(a_stalled_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_NEXT(a_no_rsp_after_reset, clock, 1'b0, reset, !rsp_valid)

endmodule

bind dhcp_fqdn_flag_rewriter_unit dfr_checker u_dfr_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

`default_nettype wire

FILE: test/testbench.sv
// testbench for dhcp_fqdn_flag_rewriter_unit: streams dhcpv4 packets byte by byte
// and checks each result against a predictor of the option walk
// depends on dfr_pkg and the rewriter rtl
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR_LEN           = dfr_pkg::HEADER_LENGTH_DEFAULT;
   localparam int POS_BITS          = dfr_pkg::POSITION_WIDTH_DEFAULT;
   localparam int CYCLE_LIMIT       = 50_000;
   localparam int TAIL_CYCLES       = 16;
   localparam logic [7:0] OPT_OTHER = 8'd12;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   dfr_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   dfr_pkg::rsp_type rsp_data;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   logic [7:0]       pkt[$];
   dfr_pkg::rsp_type outgoing[$];

   // predictor copy of the parse state
   logic [POS_BITS-1:0]  walk_pos;
   dfr_pkg::phase_type   walk_phase;
   logic [31:0]          cookie_bits;
   logic [7:0]           body_left;
   logic                 fqdn_open;
   logic                 flags_pending;
   dfr_pkg::status_type  latched_status;

   dhcp_fqdn_flag_rewriter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void clear_walk();
      walk_pos       = '0;
      walk_phase     = dfr_pkg::PH_HEADER;
      cookie_bits    = '0;
      body_left      = '0;
      fqdn_open      = 1'b0;
      flags_pending  = 1'b0;
      latched_status = dfr_pkg::ST_OK;
   endfunction

   function automatic dfr_pkg::rsp_type rewrite_byte(logic [7:0] b, logic last);
      dfr_pkg::rsp_type    r;
      dfr_pkg::status_type st;
      logic [7:0]          ob;
      ob = b;
      st = dfr_pkg::ST_OK;
      if (walk_pos != {POS_BITS{1'b1}})
         walk_pos = walk_pos + 1'b1;
      case (walk_phase)
         dfr_pkg::PH_HEADER: begin
            if (walk_pos >= HDR_LEN)
               walk_phase = dfr_pkg::PH_COOKIE;
         end
         dfr_pkg::PH_COOKIE: begin
            cookie_bits = {cookie_bits[23:0], b};
            if (walk_pos >= HDR_LEN + dfr_pkg::COOKIE_BYTES) begin
               if (cookie_bits == dfr_pkg::MAGIC_COOKIE) begin
                  walk_phase = dfr_pkg::PH_CODE;
               end else begin
                  latched_status = dfr_pkg::ST_BAD_COOKIE;
                  walk_phase     = dfr_pkg::PH_DONE;
               end
            end
         end
         dfr_pkg::PH_CODE: begin
            if (b == dfr_pkg::OPT_END) begin
               walk_phase = dfr_pkg::PH_DONE;
            end else if (b != dfr_pkg::OPT_PAD) begin
               fqdn_open  = (b == dfr_pkg::OPT_FQDN);
               walk_phase = dfr_pkg::PH_LEN;
            end
         end
         dfr_pkg::PH_LEN: begin
            body_left = b;
            if (b == 8'd0) begin
               fqdn_open  = 1'b0;
               walk_phase = dfr_pkg::PH_CODE;
            end else begin
               flags_pending = fqdn_open;
               walk_phase    = dfr_pkg::PH_BODY;
            end
         end
         dfr_pkg::PH_BODY: begin
            if (flags_pending &&
                (b & dfr_pkg::FLAG_TEST_MASK) == dfr_pkg::FLAG_TEST_MASK)
               ob = b & dfr_pkg::FLAG_CLEAR_MASK;
            flags_pending = 1'b0;
            body_left     = body_left - 1'b1;
            if (body_left == 8'd0) begin
               fqdn_open  = 1'b0;
               walk_phase = dfr_pkg::PH_CODE;
            end
         end
         default: walk_phase = dfr_pkg::PH_DONE;
      endcase
      if (last) begin
         if (walk_phase == dfr_pkg::PH_HEADER)
            st = dfr_pkg::ST_SHORT_HEADER;
         else if (walk_phase == dfr_pkg::PH_COOKIE)
            st = (walk_pos == HDR_LEN) ? dfr_pkg::ST_NO_OPTIONS : dfr_pkg::ST_SHORT_COOKIE;
         else
            st = latched_status;
      end
      r.out_byte = ob;
      r.out_last = last;
      r.drop     = (st != dfr_pkg::ST_OK);
      r.status   = st;
      if (last)
         clear_walk();
      return r;
   endfunction

   // checks each result in order, then predicts the request taken at this edge
   always @(posedge clock) begin
      dfr_pkg::rsp_type want;
      if (reset) begin
         clear_walk();
         outgoing.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outgoing.size() == 0) begin
               $error("response with nothing pending: %h", rsp_data);
               fail_count++;
            end else begin
               want = outgoing.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last: expected %b, got %b", want.out_last, rsp_data.out_last);
                  fail_count++;
               end
               if (rsp_data.drop !== want.drop) begin
                  $error("drop: expected %b, got %b", want.drop, rsp_data.drop);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            outgoing.push_back(rewrite_byte(req_data.data_byte, req_data.is_last));
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, is_last: last};
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt.size(); i++)
         send_byte(pkt[i], i == pkt.size() - 1);
      pkt.delete();
   endtask

   task automatic add_random(input int count);
      repeat (count) pkt.push_back(8'($urandom_range(255)));
   endtask

   task automatic add_cookie();
      logic [31:0] cookie = dfr_pkg::MAGIC_COOKIE;
      for (int k = dfr_pkg::COOKIE_BYTES - 1; k >= 0; k--)
         pkt.push_back(cookie[8*k +: 8]);
   endtask

   // code, length, then a chosen first body byte and random filler
   task automatic add_option(input logic [7:0] code, input logic [7:0] len,
                             input logic [7:0] first);
      pkt.push_back(code);
      pkt.push_back(len);
      if (len != 8'd0)
         pkt.push_back(first);
      for (int k = 1; k < len; k++)
         pkt.push_back(8'($urandom_range(255)));
   endtask

   // ends in the header, right after it, and inside the cookie
   task automatic test_short_packets();
      int lens[3] = '{1, HDR_LEN, HDR_LEN + 2};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      foreach (lens[i]) begin
         add_random(HDR_LEN);
         add_cookie();
         while (pkt.size() > lens[i])
            void'(pkt.pop_back());
         send_packet();
      end
   endtask

   task automatic test_cookie_check();
      int at;
      send_idle_pct = 86;
      rsp_stall_pct = 0;
      // one wrong cookie byte; the fqdn flags after it must stay as they are
      add_random(HDR_LEN);
      add_cookie();
      at      = HDR_LEN + int'($urandom_range(dfr_pkg::COOKIE_BYTES - 1));
      pkt[at] = pkt[at] ^ 8'h10;
      add_option(dfr_pkg::OPT_FQDN, 8'd3, 8'h09);
      pkt.push_back(dfr_pkg::OPT_END);
      send_packet();
   endtask

   task automatic test_option_walk();
      send_idle_pct = 0;
      rsp_stall_pct = 86;
      add_random(HDR_LEN);
      add_cookie();
      pkt.push_back(dfr_pkg::OPT_PAD);
      pkt.push_back(dfr_pkg::OPT_PAD);
      add_option(dfr_pkg::OPT_FQDN, 8'd3, 8'h09);
      add_option(OPT_OTHER, 8'd2, 8'h09);
      add_option(dfr_pkg::OPT_FQDN, 8'd0, 8'h09);
      add_option(dfr_pkg::OPT_FQDN, 8'd1, 8'h08);
      add_option(dfr_pkg::OPT_FQDN, 8'd1, 8'h01);
      add_option(dfr_pkg::OPT_FQDN, 8'd4, 8'hFF);
      add_option(dfr_pkg::OPT_FQDN, 8'd2, 8'h0F);
      pkt.push_back(dfr_pkg::OPT_END);
      // trailing bytes look like an fqdn option but are past the end
      pkt.push_back(dfr_pkg::OPT_FQDN);
      pkt.push_back(8'd1);
      pkt.push_back(8'h09);
      send_packet();
   endtask

   task automatic test_truncated_options();
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      // cut inside the body, after the flags byte has gone out
      add_random(HDR_LEN);
      add_cookie();
      add_option(dfr_pkg::OPT_FQDN, 8'd5, 8'h0B);
      while (pkt.size() > HDR_LEN + dfr_pkg::COOKIE_BYTES + 4)
         void'(pkt.pop_back());
      send_packet();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_packets();
      test_cookie_check();
      test_option_walk();
      test_truncated_options();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (outgoing.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
